FILE: rtl/eegpp_pkg.sv
// shared types and constants for the eeg headset packet parser
`default_nettype none

package eegpp_pkg;

    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH      = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_QUALITY_DEFAULT = CfgIdxW'(1);

    localparam logic [7:0] MAX_LENGTH_RST      = 8'd169;
    localparam logic [7:0] QUALITY_DEFAULT_RST = 8'd200;

    localparam logic [7:0] SYNC_BYTE       = 8'hAA;
    localparam logic [7:0] CODE_QUALITY    = 8'h02;
    localparam logic [7:0] CODE_ATTENTION  = 8'h04;
    localparam logic [7:0] CODE_MEDITATION = 8'h05;
    localparam logic [7:0] CODE_SKIP_SHORT = 8'h80;
    localparam logic [7:0] CODE_SKIP_LONG  = 8'h83;

    localparam logic [4:0] SKIP_SHORT_LEN = 5'd3;
    localparam logic [4:0] SKIP_LONG_LEN  = 5'd25;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef enum logic [4:0] {
        PH_SYNC1   = 5'b00001,
        PH_SYNC2   = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        PEND_NONE       = 2'd0,
        PEND_QUALITY    = 2'd1,
        PEND_ATTENTION  = 2'd2,
        PEND_MEDITATION = 2'd3
    } t_pend;

    // what the framing core hands to the result stage at the end of a packet
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] attention;
        logic [7:0] meditation;
        logic [7:0] quality;
        logic       seen;
    } t_commit;

endpackage

`default_nettype wire

FILE: rtl/eegpp_intf.sv
// valid/ready channel interfaces for bytes, register writes and results
`default_nettype none

interface eegpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface eegpp_cfg_if;
    import eegpp_pkg::*;

    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [7:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface eegpp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] attention_raw;
    logic [7:0] meditation_raw;
    logic [4:0] attention_level;
    logic [4:0] meditation_level;
    logic [7:0] signal_quality;
    logic       quality_seen;

    modport source (
        output valid, output status, output attention_raw, output meditation_raw,
        output attention_level, output meditation_level, output signal_quality,
        output quality_seen, input ready
    );
    modport sink (
        input valid, input status, input attention_raw, input meditation_raw,
        input attention_level, input meditation_level, input signal_quality,
        input quality_seen, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/eeg_headset_packet_parser_unit.sv
// top level of the eeg headset packet parser
//
// i_rx carries one serial byte per request. The parser hunts two 0xAA sync
// bytes, reads a length byte, decodes quality, attention and meditation
// fields on the fly and checks the trailing checksum byte.
// o_res carries one result per packet end: good, checksum mismatch, or a
// length above max_length. Values are committed only on a good checksum.
// i_cfg writes max_length (index 0) and quality_default (index 1); other
// indexes are ignored. i_cfg.ready is always high.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// combinational framing update between the input byte register and the result
// register. A byte that ends a packet passes through the input register and
// then the result register before its result is valid on o_res.
// When the receiver stalls, the result register holds; bytes that cause
// no result keep flowing, and a byte that would cause one waits in the
// input register, which then drops i_rx.ready.
// Reset (synchronous, active low) returns to hunting, clears held values
// and loads max_length 169 and quality_default 200.
`default_nettype none

module eeg_headset_packet_parser_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    eegpp_byte_if.sink  i_rx,
    eegpp_cfg_if.sink   i_cfg,
    eegpp_res_if.source o_res
);
    import eegpp_pkg::*;

    logic [7:0] r_max_length;
    logic [7:0] r_quality_default;
    logic       cmt_valid;
    logic       cmt_ready;
    t_commit    cmt;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length      <= MAX_LENGTH_RST;
            r_quality_default <= QUALITY_DEFAULT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MAX_LENGTH:      r_max_length      <= i_cfg.data;
                CFG_QUALITY_DEFAULT: r_quality_default <= i_cfg.data;
                default: ;
            endcase
        end
    end

    eegpp_frame_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx              (i_rx),
        .i_max_length      (r_max_length),
        .i_quality_default (r_quality_default),
        .o_cmt_valid       (cmt_valid),
        .o_cmt             (cmt),
        .i_cmt_ready       (cmt_ready)
    );

    eegpp_result_reg u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmt_valid (cmt_valid),
        .i_cmt       (cmt),
        .o_cmt_ready (cmt_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

FILE: rtl/eegpp_frame_core.sv
// input byte register and packet framing, checksum and field decoding
`default_nettype none

module eegpp_frame_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    eegpp_byte_if.sink             i_rx,
    input  wire logic [7:0]        i_max_length,
    input  wire logic [7:0]        i_quality_default,
    output      logic              o_cmt_valid,
    output      eegpp_pkg::t_commit o_cmt,
    input  wire logic              i_cmt_ready
);
    import eegpp_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;

    t_phase     r_phase,   n_phase;
    logic [7:0] r_len,     n_len;
    logic [7:0] r_taken,   n_taken;
    logic [7:0] r_sum,     n_sum;
    logic [4:0] r_skip,    n_skip;
    t_pend      r_pend,    n_pend;
    logic [7:0] r_t_att,   n_t_att;
    logic [7:0] r_t_med,   n_t_med;
    logic [7:0] r_t_qual,  n_t_qual;
    logic       r_t_seen,  n_t_seen;
    logic [7:0] r_h_att,   n_h_att;
    logic [7:0] r_h_med,   n_h_med;
    logic [7:0] r_h_qual,  n_h_qual;
    logic       r_h_seen,  n_h_seen;

    logic       emit;
    logic [1:0] status;
    logic       advance;
    logic       fire;
    logic [7:0] b;

    assign b       = r_in_byte;
    assign advance = !emit || i_cmt_ready;
    assign fire    = r_in_vld && advance;
    assign i_rx.ready = !r_in_vld || advance;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_taken  = r_taken;
        n_sum    = r_sum;
        n_skip   = r_skip;
        n_pend   = r_pend;
        n_t_att  = r_t_att;
        n_t_med  = r_t_med;
        n_t_qual = r_t_qual;
        n_t_seen = r_t_seen;
        n_h_att  = r_h_att;
        n_h_med  = r_h_med;
        n_h_qual = r_h_qual;
        n_h_seen = r_h_seen;
        emit     = 1'b0;
        status   = STATUS_GOOD;
        case (r_phase)
            PH_SYNC1: begin
                n_phase = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
            end
            PH_SYNC2: begin
                n_phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
            end
            PH_LEN: begin
                if (b > i_max_length) begin
                    emit    = 1'b1;
                    status  = STATUS_TOO_LONG;
                    n_phase = PH_SYNC1;
                end else begin
                    n_len    = b;
                    n_taken  = 8'd0;
                    n_sum    = 8'd0;
                    n_skip   = 5'd0;
                    n_pend   = PEND_NONE;
                    n_t_att  = 8'd0;
                    n_t_med  = 8'd0;
                    n_t_qual = i_quality_default;
                    n_t_seen = 1'b0;
                    n_phase  = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum = r_sum + b;
                if (r_skip != 5'd0) begin
                    n_skip = r_skip - 5'd1;
                end else if (r_pend == PEND_QUALITY) begin
                    n_t_qual = b;
                    n_t_seen = 1'b1;
                    n_pend   = PEND_NONE;
                end else if (r_pend == PEND_ATTENTION) begin
                    n_t_att = b;
                    n_pend  = PEND_NONE;
                end else if (r_pend == PEND_MEDITATION) begin
                    n_t_med = b;
                    n_pend  = PEND_NONE;
                end else if (b == CODE_QUALITY) begin
                    n_pend = PEND_QUALITY;
                end else if (b == CODE_ATTENTION) begin
                    n_pend = PEND_ATTENTION;
                end else if (b == CODE_MEDITATION) begin
                    n_pend = PEND_MEDITATION;
                end else if (b == CODE_SKIP_SHORT) begin
                    n_skip = SKIP_SHORT_LEN;
                end else if (b == CODE_SKIP_LONG) begin
                    n_skip = SKIP_LONG_LEN;
                end
                // taken stays below the length here, so the increment never wraps
                n_taken = r_taken + 8'd1;
                if (n_taken >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                emit    = 1'b1;
                n_phase = PH_SYNC1;
                if (b == ~r_sum) begin
                    status   = STATUS_GOOD;
                    n_h_att  = r_t_att;
                    n_h_med  = r_t_med;
                    n_h_qual = r_t_qual;
                    n_h_seen = r_h_seen | r_t_seen;
                end else begin
                    status = STATUS_BAD_SUM;
                end
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    assign o_cmt_valid     = r_in_vld && emit;
    assign o_cmt.status    = status;
    assign o_cmt.attention = n_h_att;
    assign o_cmt.meditation = n_h_med;
    assign o_cmt.quality   = n_h_qual;
    assign o_cmt.seen      = n_h_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_len    <= 8'd0;
            r_taken  <= 8'd0;
            r_sum    <= 8'd0;
            r_skip   <= 5'd0;
            r_pend   <= PEND_NONE;
            r_t_att  <= 8'd0;
            r_t_med  <= 8'd0;
            r_t_qual <= QUALITY_DEFAULT_RST;
            r_t_seen <= 1'b0;
            r_h_att  <= 8'd0;
            r_h_med  <= 8'd0;
            r_h_qual <= 8'd0;
            r_h_seen <= 1'b0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_taken  <= n_taken;
            r_sum    <= n_sum;
            r_skip   <= n_skip;
            r_pend   <= n_pend;
            r_t_att  <= n_t_att;
            r_t_med  <= n_t_med;
            r_t_qual <= n_t_qual;
            r_t_seen <= n_t_seen;
            r_h_att  <= n_h_att;
            r_h_med  <= n_h_med;
            r_h_qual <= n_h_qual;
            r_h_seen <= n_h_seen;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/eegpp_result_reg.sv
// result register with the divide-by-ten level computation
`default_nettype none

module eegpp_result_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmt_valid,
    input  wire eegpp_pkg::t_commit i_cmt,
    output      logic               o_cmt_ready,
    eegpp_res_if.source             o_res
);
    import eegpp_pkg::*;

    logic       r_vld;
    t_commit    r_cmt;
    logic [4:0] r_att_lvl;
    logic [4:0] r_med_lvl;
    logic [4:0] n_att_lvl;
    logic [4:0] n_med_lvl;
    logic [15:0] att_prod;
    logic [15:0] med_prod;

    // x / 10 == (x * 205) >> 11 for every 8-bit x
    assign att_prod  = 16'(i_cmt.attention) * 16'd205;
    assign med_prod  = 16'(i_cmt.meditation) * 16'd205;
    assign n_att_lvl = att_prod[15:11];
    assign n_med_lvl = med_prod[15:11];

    assign o_cmt_ready = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_cmt_ready) begin
            r_vld <= i_cmt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmt_ready && i_cmt_valid) begin
            r_cmt     <= i_cmt;
            r_att_lvl <= n_att_lvl;
            r_med_lvl <= n_med_lvl;
        end
    end

    assign o_res.valid            = r_vld;
    assign o_res.status           = r_cmt.status;
    assign o_res.attention_raw    = r_cmt.attention;
    assign o_res.meditation_raw   = r_cmt.meditation;
    assign o_res.attention_level  = r_att_lvl;
    assign o_res.meditation_level = r_med_lvl;
    assign o_res.signal_quality   = r_cmt.quality;
    assign o_res.quality_seen     = r_cmt.seen;

endmodule

`default_nettype wire
